[rtl/bfa_pkg.sv]
// Package for the bitmap frame allocator: sizes, codes, state and bus types.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package bfa_pkg;

  localparam int unsigned FRAME_COUNT = 65536;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned FRAME_W     = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned WORD_AW     = FRAME_W - BIT_W;
  localparam int unsigned MAX_WORDS   = 2 ** WORD_AW;
  localparam int unsigned RAW_WORDS   = FRAME_COUNT / WORD_BITS;
  localparam int unsigned USED_WORDS  = (RAW_WORDS < MAX_WORDS) ? RAW_WORDS : MAX_WORDS;

  typedef logic [WORD_AW-1:0]   word_addr_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;
  typedef logic [FRAME_W-1:0]   frame_t;

  localparam word_addr_t         LAST_WORD  = WORD_AW'(USED_WORDS - 1);
  localparam logic [WORD_AW:0]   WORD_LIMIT = (WORD_AW + 1)'(USED_WORDS);
  localparam word_t              FULL_WORD  = '1;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } bfa_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_MAPPED    = 3'd1,
    ST_NO_FRAME  = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOTHING   = 3'd4
  } bfa_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_EMIT
  } bfa_state_e;

  typedef struct packed {
    bfa_status_e status;
    frame_t      frame_number;
    logic        present;
    logic        writable;
    logic        user;
  } bfa_result_t;

  typedef struct packed {
    logic       en;
    word_addr_t addr;
  } bfa_ram_rd_t;

  typedef struct packed {
    logic       en;
    word_addr_t addr;
    word_t      data;
  } bfa_ram_wr_t;

endpackage

`default_nettype wire

[rtl/bfa_if.sv]
// Valid/ready channel interfaces for allocation requests and results.
// Widths come from bfa_pkg.
`default_nettype none

interface bfa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [bfa_pkg::FRAME_W-1:0] current_frame;
  logic                      kernel_page;
  logic                      map_writable;

  modport source (output valid, kind, current_frame, kernel_page, map_writable, input ready);
  modport sink   (input valid, kind, current_frame, kernel_page, map_writable, output ready);
endinterface

interface bfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bfa_pkg::STATUS_W-1:0] status;
  logic [bfa_pkg::FRAME_W-1:0]  frame_number;
  logic                         present;
  logic                         writable;
  logic                         user;

  modport source (output valid, status, frame_number, present, writable, user, input ready);
  modport sink   (input valid, status, frame_number, present, writable, user, output ready);
endinterface

`default_nettype wire

[rtl/bitmap_frame_allocator_unit.sv]
// Top level of the bitmap frame allocator: sequencer, scan hint and result register.
// Depends on bfa_pkg, bfa_if, bfa_bitmap_ram and bfa_find_zero.
//
//   channel  | dir | fields
//   ---------+-----+--------------------------------------------------------
//   req_i    | in  | kind, current_frame, kernel_page, map_writable
//   rsp_o    | out | status, frame_number, present, writable, user
//
// One request is in work at a time. Requests that need no bitmap access go from
// idle straight to the emit step, a free reads its bitmap word and then writes it
// back, and an allocation makes one bitmap read per word scanned, starting at
// the lowest word that may still hold a clear bit. After reset a clearing pass
// writes every used bitmap word before the first request is taken.
// A new request is taken while a finished result still waits in the register.
`default_nettype none

module bitmap_frame_allocator_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfa_req_if.sink   req_i,
  bfa_rsp_if.source rsp_o
);

  bfa_pkg::bfa_state_e  state_q, state_d;
  bfa_pkg::word_addr_t  addr_q, addr_d;
  bfa_pkg::word_addr_t  hint_q, hint_d;
  logic                 out_valid_q, out_valid_d;
  bfa_pkg::bfa_result_t out_q, out_d;
  bfa_pkg::bfa_result_t res_q, res_d;
  bfa_pkg::bit_idx_t    bit_q, bit_d;
  logic                 wr_q, wr_d;
  logic                 user_q, user_d;

  bfa_pkg::bfa_ram_rd_t ram_rd;
  bfa_pkg::bfa_ram_wr_t ram_wr;
  bfa_pkg::word_t       rdata;
  logic                 zero_found;
  bfa_pkg::bit_idx_t    zero_index;
  bfa_pkg::word_t       zero_mask;
  bfa_pkg::word_addr_t  req_word;
  logic                 req_in_range;

  bfa_bitmap_ram u_ram (
    .clk_i   (clk_i),
    .rd_i    (ram_rd),
    .wr_i    (ram_wr),
    .rdata_o (rdata)
  );

  bfa_find_zero u_find (
    .word_i  (rdata),
    .found_o (zero_found),
    .index_o (zero_index),
    .mask_o  (zero_mask)
  );

  assign req_word     = req_i.current_frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
  assign req_in_range = ({1'b0, req_word} < bfa_pkg::WORD_LIMIT);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    hint_d      = hint_q;
    res_d       = res_q;
    bit_d       = bit_q;
    wr_d        = wr_q;
    user_d      = user_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_rd      = '0;
    ram_wr      = '0;
    req_i.ready = 1'b0;

    unique case (state_q)
      bfa_pkg::S_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = addr_q;
        ram_wr.data = '0;
        if (addr_q == bfa_pkg::LAST_WORD) begin
          addr_d  = '0;
          state_d = bfa_pkg::S_IDLE;
        end else begin
          addr_d = addr_q + bfa_pkg::word_addr_t'(1);
        end
      end

      bfa_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          wr_d   = req_i.map_writable;
          user_d = ~req_i.kernel_page;
          bit_d  = req_i.current_frame[bfa_pkg::BIT_W-1:0];
          addr_d = req_word;
          res_d  = '{status: bfa_pkg::ST_NOTHING, frame_number: '0,
                     present: 1'b0, writable: 1'b0, user: 1'b0};
          state_d = bfa_pkg::S_EMIT;
          if (bfa_pkg::bfa_kind_e'(req_i.kind) == bfa_pkg::KIND_ALLOC) begin
            if (req_i.current_frame != '0) begin
              res_d.status       = bfa_pkg::ST_MAPPED;
              res_d.frame_number = req_i.current_frame;
            end else begin
              ram_rd.en   = 1'b1;
              ram_rd.addr = hint_q;
              addr_d      = hint_q;
              state_d     = bfa_pkg::S_SCAN;
            end
          end else if (req_i.current_frame != '0) begin
            res_d.status = bfa_pkg::ST_FREED;
            // Frames beyond the used words are reported freed without a write.
            if (req_in_range) begin
              ram_rd.en   = 1'b1;
              ram_rd.addr = req_word;
              state_d     = bfa_pkg::S_FREE;
            end
          end
        end
      end

      bfa_pkg::S_SCAN: begin
        if (zero_found) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = addr_q;
          ram_wr.data = rdata | zero_mask;
          hint_d      = addr_q;
          res_d       = '{status: bfa_pkg::ST_ALLOCATED, frame_number: {addr_q, zero_index},
                          present: 1'b1, writable: wr_q, user: user_q};
          state_d     = bfa_pkg::S_EMIT;
        end else if (addr_q == bfa_pkg::LAST_WORD) begin
          res_d   = '{status: bfa_pkg::ST_NO_FRAME, frame_number: '0,
                      present: 1'b0, writable: 1'b0, user: 1'b0};
          state_d = bfa_pkg::S_EMIT;
        end else begin
          addr_d      = addr_q + bfa_pkg::word_addr_t'(1);
          ram_rd.en   = 1'b1;
          ram_rd.addr = addr_q + bfa_pkg::word_addr_t'(1);
        end
      end

      bfa_pkg::S_FREE: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = addr_q;
        ram_wr.data = rdata & ~(bfa_pkg::word_t'(1) << bit_q);
        // Every word below the hint is full, so a freed word below the hint lowers it.
        if (addr_q < hint_q) begin
          hint_d = addr_q;
        end
        state_d = bfa_pkg::S_EMIT;
      end

      bfa_pkg::S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = bfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bfa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfa_pkg::S_CLEAR;
      addr_q      <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    out_q  <= out_d;
    bit_q  <= bit_d;
    wr_q   <= wr_d;
    user_q <= user_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.frame_number = out_q.frame_number;
  assign rsp_o.present      = out_q.present;
  assign rsp_o.writable     = out_q.writable;
  assign rsp_o.user         = out_q.user;

  a_hint_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= bfa_pkg::LAST_WORD)
    else $error("scan hint beyond the used bitmap words");

  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr.en |-> (state_q == bfa_pkg::S_CLEAR || state_q == bfa_pkg::S_SCAN ||
                   state_q == bfa_pkg::S_FREE))
    else $error("bitmap written outside clear, scan or free");

  a_result_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == bfa_pkg::S_EMIT))
    else $error("result loaded outside the emit step");

  a_present_on_alloc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.present == (rsp_o.status == bfa_pkg::ST_ALLOCATED)))
    else $error("present flag disagrees with status");

endmodule

`default_nettype wire

[rtl/bfa_bitmap_ram.sv]
// Frame bitmap storage: one write port and one read port, read data registered.
// Depends on bfa_pkg for the word and address types.
`default_nettype none

module bfa_bitmap_ram (
  input  wire logic                 clk_i,
  input  wire bfa_pkg::bfa_ram_rd_t rd_i,
  input  wire bfa_pkg::bfa_ram_wr_t wr_i,
  output bfa_pkg::word_t            rdata_o
);

  bfa_pkg::word_t mem [bfa_pkg::MAX_WORDS];
  bfa_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // A read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/bfa_find_zero.sv]
// Finds the lowest clear bit of one bitmap word.
// Depends on bfa_pkg for the word and index types.
`default_nettype none

module bfa_find_zero (
  input  wire bfa_pkg::word_t word_i,
  output logic                found_o,
  output bfa_pkg::bit_idx_t   index_o,
  output bfa_pkg::word_t      mask_o
);

  bfa_pkg::word_t onehot;

  // Adding one carries through the trailing ones and lands on the lowest zero.
  assign onehot  = ~word_i & (word_i + bfa_pkg::word_t'(1));
  assign found_o = (word_i != bfa_pkg::FULL_WORD);
  assign mask_o  = onehot;

  always_comb begin
    index_o = '0;
    for (int i = 0; i < int'(bfa_pkg::WORD_BITS); i++) begin
      if (onehot[i]) begin
        index_o = index_o | bfa_pkg::bit_idx_t'(i);
      end
    end
  end

endmodule

`default_nettype wire
